// ----- src/biou_pkg.sv -----
// Shared types and constants for the box overlap ratio pipeline.
package biou_pkg;

    // Fixed field widths of the stream payload and the bias register
    localparam int AREA_W = 32;
    localparam int BIAS_W = 16;

    localparam logic [AREA_W-1:0] AREA_MAX   = '1;
    localparam logic [BIAS_W-1:0] BIAS_RESET = 16'd1;

    // Per-request flags and the clamped area, carried beside the divider data
    typedef struct packed {
        logic              degen;
        logic              sat;
        logic [AREA_W-1:0] area;
    } biou_side_t;

endpackage

// ----- src/box_iou_unit.sv -----
// Top level: stream wrapper, bias register, divider chain and output register.
//
// Intersection over union of two axis-aligned boxes, one box pair per request.
// Input: s_axis_* carries the eight corner coordinates of boxes A and B.
// Output: m_axis_* carries the Q1.RATIO_FRAC_BITS ratio (2^RATIO_FRAC_BITS
// means 1.0, saturated), the intersection area clamped to 32 bits, and in
// tuser a flag that is set when the union is not positive (ratio then 0).
// Configuration: cfg_wr_en writes cfg_wr_data into the union bias register;
// write it only while no request is in flight.
// Throughput: one request per cycle, sustained while the output is not held.
// Pipeline: four front stages for extents, products, union and divider
// setup, one divider cell per quotient bit, then the output register.
// Reset: all stages empty, union bias set to 1.
// Stall: a held output stops only the stages behind it that are full; empty
// stages keep closing up, so s_axis_tready stays high while bubbles remain.
module box_iou_unit #(
    parameter int COORD_WIDTH     = 16,
    parameter int RATIO_FRAC_BITS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Configuration
    input  logic                              cfg_wr_en,
    input  logic [biou_pkg::BIAS_W-1:0]       cfg_wr_data,
    // Input stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // tdata, low bit up: box_a_x1, box_a_y1, box_a_x2, box_a_y2,
    //                    box_b_x1, box_b_y1, box_b_x2, box_b_y2
    input  logic [8*COORD_WIDTH-1:0]          s_axis_tdata,
    // Output stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // tdata, low bit up: overlap_ratio, overlap_area, zero fill
    output logic [((RATIO_FRAC_BITS+33+7)/8)*8-1:0] m_axis_tdata,
    // tuser: degenerate
    output logic                              m_axis_tuser
);
    import biou_pkg::*;

    localparam int C      = COORD_WIDTH;
    localparam int R      = RATIO_FRAC_BITS;
    localparam int DW     = 2 * C + 2;
    localparam int RAT_W  = R + 1;
    localparam int OUT_W  = ((R + 33 + 7) / 8) * 8;
    localparam int FILL_W = OUT_W - RAT_W - AREA_W;

    // Union bias register
    logic [BIAS_W-1:0] union_bias_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            union_bias_reg <= BIAS_RESET;
        end else if (cfg_wr_en) begin
            union_bias_reg <= cfg_wr_data;
        end
    end

    // Chain links: index 0 is the front end, index R the last cell
    logic             link_valid [0:R];
    logic             link_ready [0:R];
    logic [DW-1:0]    link_rem   [0:R];
    logic [DW-1:0]    link_den   [0:R];
    logic [R-1:0]     link_quo   [0:R];
    biou_side_t       link_side  [0:R];

    assign link_quo[0] = '0;

    biou_geom #(
        .C (C)
    ) u_geom (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .union_bias (union_bias_reg),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .a_x1       (s_axis_tdata[0*C +: C]),
        .a_y1       (s_axis_tdata[1*C +: C]),
        .a_x2       (s_axis_tdata[2*C +: C]),
        .a_y2       (s_axis_tdata[3*C +: C]),
        .b_x1       (s_axis_tdata[4*C +: C]),
        .b_y1       (s_axis_tdata[5*C +: C]),
        .b_x2       (s_axis_tdata[6*C +: C]),
        .b_y2       (s_axis_tdata[7*C +: C]),
        .out_valid  (link_valid[0]),
        .out_ready  (link_ready[0]),
        .out_rem    (link_rem[0]),
        .out_den    (link_den[0]),
        .out_side   (link_side[0])
    );

    // Divider chain, one quotient bit per cell
    for (genvar i = 0; i < R; i++) begin : g_cell
        biou_div_cell #(
            .DW (DW),
            .QW (R)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (link_valid[i]),
            .in_ready  (link_ready[i]),
            .in_rem    (link_rem[i]),
            .in_den    (link_den[i]),
            .in_quo    (link_quo[i]),
            .in_side   (link_side[i]),
            .out_valid (link_valid[i+1]),
            .out_ready (link_ready[i+1]),
            .out_rem   (link_rem[i+1]),
            .out_den   (link_den[i+1]),
            .out_quo   (link_quo[i+1]),
            .out_side  (link_side[i+1])
        );
    end

    // Output register: pick zero, full scale or the quotient
    logic               m_valid_reg;
    logic               out_adv;
    logic [RAT_W-1:0]   ratio_next, ratio_reg;
    logic [AREA_W-1:0]  area_reg;
    logic               degen_reg;

    assign out_adv        = !m_valid_reg || m_axis_tready;
    assign link_ready[R]  = out_adv;

    always_comb begin
        priority if (link_side[R].degen) begin
            ratio_next = '0;
        end else if (link_side[R].sat) begin
            ratio_next = {1'b1, {R{1'b0}}};
        end else begin
            ratio_next = {1'b0, link_quo[R]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_adv) begin
            m_valid_reg <= link_valid[R];
        end
    end

    always_ff @(posedge aclk) begin
        if (out_adv) begin
            ratio_reg <= ratio_next;
            area_reg  <= link_side[R].area;
            degen_reg <= link_side[R].degen;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{FILL_W{1'b0}}, area_reg, ratio_reg};
    assign m_axis_tuser  = degen_reg;

endmodule

// ----- src/biou_geom.sv -----
// Front pipeline: overlap extents, products, union and divider setup.
module biou_geom #(
    parameter int C = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [biou_pkg::BIAS_W-1:0]  union_bias,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [C-1:0]          a_x1,
    input  logic signed [C-1:0]          a_y1,
    input  logic signed [C-1:0]          a_x2,
    input  logic signed [C-1:0]          a_y2,
    input  logic signed [C-1:0]          b_x1,
    input  logic signed [C-1:0]          b_y1,
    input  logic signed [C-1:0]          b_x2,
    input  logic signed [C-1:0]          b_y2,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [2*C+1:0]               out_rem,
    output logic [2*C+1:0]               out_den,
    output biou_pkg::biou_side_t         out_side
);
    import biou_pkg::*;

    localparam int INTER_W = 2 * C;
    localparam int PROD_W  = 2 * C + 2;
    localparam int UNI_W   = 2 * C + 3;
    localparam int DIV_W   = 2 * C + 2;
    localparam int EXT_W   = (INTER_W > AREA_W) ? INTER_W : AREA_W;

    // Stage valids and advance chain
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic adv1, adv2, adv3, adv4;

    assign adv4     = !v4_reg || out_ready;
    assign adv3     = !v3_reg || adv4;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign in_ready = adv1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (adv1) v1_reg <= in_valid;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
            if (adv4) v4_reg <= v3_reg;
        end
    end

    // Stage 1: overlap extents clamped at zero, box side lengths
    logic signed [C-1:0] min_x2, max_x1, min_y2, max_y1;
    logic signed [C:0]   iw_raw, ih_raw;
    logic [C-1:0]        iw_next, ih_next;
    logic signed [C:0]   wa_next, ha_next, wb_next, hb_next;
    logic [C-1:0]        iw_reg, ih_reg;
    logic signed [C:0]   wa_reg, ha_reg, wb_reg, hb_reg;

    always_comb begin
        min_x2  = (a_x2 < b_x2) ? a_x2 : b_x2;
        max_x1  = (a_x1 > b_x1) ? a_x1 : b_x1;
        min_y2  = (a_y2 < b_y2) ? a_y2 : b_y2;
        max_y1  = (a_y1 > b_y1) ? a_y1 : b_y1;
        iw_raw  = $signed({min_x2[C-1], min_x2}) - $signed({max_x1[C-1], max_x1});
        ih_raw  = $signed({min_y2[C-1], min_y2}) - $signed({max_y1[C-1], max_y1});
        iw_next = iw_raw[C] ? '0 : iw_raw[C-1:0];
        ih_next = ih_raw[C] ? '0 : ih_raw[C-1:0];
        wa_next = $signed({a_x2[C-1], a_x2}) - $signed({a_x1[C-1], a_x1});
        ha_next = $signed({a_y2[C-1], a_y2}) - $signed({a_y1[C-1], a_y1});
        wb_next = $signed({b_x2[C-1], b_x2}) - $signed({b_x1[C-1], b_x1});
        hb_next = $signed({b_y2[C-1], b_y2}) - $signed({b_y1[C-1], b_y1});
    end

    always_ff @(posedge aclk) begin
        if (adv1) begin
            iw_reg <= iw_next;
            ih_reg <= ih_next;
            wa_reg <= wa_next;
            ha_reg <= ha_next;
            wb_reg <= wb_next;
            hb_reg <= hb_next;
        end
    end

    // Stage 2: intersection area and the two box areas
    logic [INTER_W-1:0]       inter2_reg;
    logic signed [PROD_W-1:0] area_a_reg, area_b_reg;

    always_ff @(posedge aclk) begin
        if (adv2) begin
            inter2_reg <= iw_reg * ih_reg;
            area_a_reg <= PROD_W'(wa_reg * ha_reg);
            area_b_reg <= PROD_W'(wb_reg * hb_reg);
        end
    end

    // Stage 3: union = areas - intersection + bias
    logic signed [UNI_W-1:0] uni_next, uni_reg;
    logic [INTER_W-1:0]      inter3_reg;

    always_comb begin
        uni_next = UNI_W'(area_a_reg) + UNI_W'(area_b_reg)
                 - $signed({3'b000, inter2_reg})
                 + $signed({{(UNI_W-BIAS_W){1'b0}}, union_bias});
    end

    always_ff @(posedge aclk) begin
        if (adv3) begin
            uni_reg    <= uni_next;
            inter3_reg <= inter2_reg;
        end
    end

    // Stage 4: classify and set up the divider
    logic                    degen_next, sat_next;
    logic [EXT_W-1:0]        inter_ext;
    logic [AREA_W-1:0]       area_next;
    logic [DIV_W-1:0]        rem_reg, den_reg;
    biou_side_t              side_reg;

    always_comb begin
        degen_next = uni_reg[UNI_W-1] || (uni_reg == '0);
        sat_next   = $signed({3'b000, inter3_reg}) >= uni_reg;
        inter_ext  = EXT_W'(inter3_reg);
        area_next  = (inter_ext > EXT_W'(AREA_MAX)) ? AREA_MAX : inter_ext[AREA_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (adv4) begin
            rem_reg        <= (degen_next || sat_next) ? '0 : DIV_W'(inter3_reg);
            den_reg        <= uni_reg[DIV_W-1:0];
            side_reg.degen <= degen_next;
            side_reg.sat   <= sat_next;
            side_reg.area  <= area_next;
        end
    end

    assign out_valid = v4_reg;
    assign out_rem   = rem_reg;
    assign out_den   = den_reg;
    assign out_side  = side_reg;

endmodule

// ----- src/biou_div_cell.sv -----
// One cell of the divider chain: develops one quotient bit per request.
module biou_div_cell #(
    parameter int DW = 34,
    parameter int QW = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [DW-1:0]         in_rem,
    input  logic [DW-1:0]         in_den,
    input  logic [QW-1:0]         in_quo,
    input  biou_pkg::biou_side_t  in_side,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [DW-1:0]         out_rem,
    output logic [DW-1:0]         out_den,
    output logic [QW-1:0]         out_quo,
    output biou_pkg::biou_side_t  out_side
);
    import biou_pkg::*;

    logic            valid_reg;
    logic            adv;
    logic [DW:0]     rem2, diff;
    logic            bit_q;
    logic [DW-1:0]   rem_reg, den_reg;
    logic [QW-1:0]   quo_reg;
    biou_side_t      side_reg;

    assign adv      = !valid_reg || out_ready;
    assign in_ready = adv;

    // Shift the remainder, subtract the divisor where it fits
    always_comb begin
        rem2  = {in_rem, 1'b0};
        diff  = rem2 - {1'b0, in_den};
        bit_q = (rem2 >= {1'b0, in_den});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            rem_reg  <= bit_q ? diff[DW-1:0] : rem2[DW-1:0];
            den_reg  <= in_den;
            quo_reg  <= {in_quo[QW-2:0], bit_q};
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_den   = den_reg;
    assign out_quo   = quo_reg;
    assign out_side  = side_reg;

endmodule

// ----- test/box_iou_check.sv -----
// Checker for box_iou_unit: predicts each overlap result and compares the output stream.
module box_iou_check #(
    parameter int COORD_W = 16,
    parameter int FRAC_W  = 16,
    parameter int M_W     = 56
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wr_en,
    input  logic [biou_pkg::BIAS_W-1:0] cfg_wr_data,
    input  logic                    s_axis_tvalid,
    input  logic                    s_axis_tready,
    input  logic [8*COORD_W-1:0]    s_axis_tdata,
    input  logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    input  logic [M_W-1:0]          m_axis_tdata,
    input  logic                    m_axis_tuser,
    output int                      mismatches,
    output int                      pending
);

    typedef struct packed {
        logic [FRAC_W:0]               ratio;
        logic [biou_pkg::AREA_W-1:0]   area;
        logic                          degen;
    } overlap_t;

    logic [biou_pkg::BIAS_W-1:0] bias_shadow;
    overlap_t                    overlap_fifo[$];

    // Exact integer IoU of one box pair under the given union bias
    function automatic overlap_t predict_overlap(logic [8*COORD_W-1:0] pair,
                                                 logic [biou_pkg::BIAS_W-1:0] bias);
        longint   c[8];
        longint   iw, ih, inter, area_a, area_b, uni;
        overlap_t r;
        int       i;
        for (i = 0; i < 8; i++) begin
            c[i] = longint'($signed(pair[COORD_W*i +: COORD_W]));
        end
        iw = ((c[2] < c[6]) ? c[2] : c[6]) - ((c[0] > c[4]) ? c[0] : c[4]);
        ih = ((c[3] < c[7]) ? c[3] : c[7]) - ((c[1] > c[5]) ? c[1] : c[5]);
        if (iw < 0) iw = 0;
        if (ih < 0) ih = 0;
        inter  = iw * ih;
        area_a = (c[2] - c[0]) * (c[3] - c[1]);
        area_b = (c[6] - c[4]) * (c[7] - c[5]);
        uni    = area_a + area_b - inter + longint'(bias);
        if (uni <= 0) begin
            r.degen = 1'b1;
            r.ratio = '0;
        end else if (inter >= uni) begin
            r.degen = 1'b0;
            r.ratio = 1 << FRAC_W;
        end else begin
            r.degen = 1'b0;
            r.ratio = (FRAC_W+1)'((inter <<< FRAC_W) / uni);
        end
        if (inter > longint'(biou_pkg::AREA_MAX))
            r.area = biou_pkg::AREA_MAX;
        else
            r.area = inter[biou_pkg::AREA_W-1:0];
        return r;
    endfunction

    initial begin
        mismatches = 0;
        pending    = 0;
    end

    // Track the bias, queue predictions on input requests, check output requests
    always @(posedge aclk) begin
        overlap_t want;
        overlap_t got;
        if (!aresetn) begin
            bias_shadow = biou_pkg::BIAS_RESET;
            overlap_fifo.delete();
        end else begin
            if (cfg_wr_en)
                bias_shadow = cfg_wr_data;
            if (s_axis_tvalid && s_axis_tready)
                overlap_fifo.push_back(predict_overlap(s_axis_tdata, bias_shadow));
            if (m_axis_tvalid && m_axis_tready) begin
                got.ratio = m_axis_tdata[FRAC_W:0];
                got.area  = m_axis_tdata[FRAC_W+1 +: biou_pkg::AREA_W];
                got.degen = m_axis_tuser;
                if (overlap_fifo.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual ratio %0d area %0d degen %0b",
                             $time, got.ratio, got.area, got.degen);
                    mismatches++;
                end else begin
                    want = overlap_fifo.pop_front();
                    if (got.ratio !== want.ratio) begin
                        $display("%0t: overlap_ratio expected %0d actual %0d",
                                 $time, want.ratio, got.ratio);
                        mismatches++;
                    end
                    if (got.area !== want.area) begin
                        $display("%0t: overlap_area expected %0d actual %0d",
                                 $time, want.area, got.area);
                        mismatches++;
                    end
                    if (got.degen !== want.degen) begin
                        $display("%0t: degenerate expected %0b actual %0b",
                                 $time, want.degen, got.degen);
                        mismatches++;
                    end
                end
            end
        end
        pending = overlap_fifo.size();
    end

endmodule

// ----- test/box_iou_unit_test.sv -----
// Testbench top for box_iou_unit: clock, reset, stimulus, bias writes and verdict.
module box_iou_unit_test;

    localparam int COORD_W     = 16;
    localparam int FRAC_W      = 16;
    localparam int M_W         = ((FRAC_W + 33 + 7) / 8) * 8;
    localparam int LATENCY     = FRAC_W + 5;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 134;

    logic                        aclk;
    logic                        aresetn;
    logic                        cfg_wr_en;
    logic [biou_pkg::BIAS_W-1:0] cfg_wr_data;
    logic                        s_axis_tvalid;
    logic                        s_axis_tready;
    // tdata, low bit up: box_a_x1, box_a_y1, box_a_x2, box_a_y2,
    //                    box_b_x1, box_b_y1, box_b_x2, box_b_y2
    logic [8*COORD_W-1:0]        s_axis_tdata;
    logic                        m_axis_tvalid;
    logic                        m_axis_tready;
    // tdata, low bit up: overlap_ratio, overlap_area, zero fill
    logic [M_W-1:0]              m_axis_tdata;
    // tuser: degenerate
    logic                        m_axis_tuser;

    int mismatches;
    int pending;
    int cycles;
    int send_idle_pct;
    int recv_idle_pct;

    box_iou_unit #(
        .COORD_WIDTH     (COORD_W),
        .RATIO_FRAC_BITS (FRAC_W)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    box_iou_check #(
        .COORD_W (COORD_W),
        .FRAC_W  (FRAC_W),
        .M_W     (M_W)
    ) check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .mismatches    (mismatches),
        .pending       (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Abort a hung run
    initial cycles = 0;
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Stall the result side at random
    always @(negedge aclk) begin
        m_axis_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end

    // Pack one box, corners clamped into the signed coordinate range
    function automatic logic [4*COORD_W-1:0] box_at(int x1, int y1, int w, int h);
        int lo;
        int hi;
        lo = -(1 << (COORD_W - 1));
        hi = (1 << (COORD_W - 1)) - 1;
        if (x1 < lo) x1 = lo;
        if (y1 < lo) y1 = lo;
        if (x1 > hi - w) x1 = hi - w;
        if (y1 > hi - h) y1 = hi - h;
        return {COORD_W'(y1 + h), COORD_W'(x1 + w), COORD_W'(y1), COORD_W'(x1)};
    endfunction

    function automatic int rand_coord();
        return int'($urandom_range(65535, 0)) - 32768;
    endfunction

    // Mostly overlapping pairs with random content, some noise and inverted boxes
    function automatic logic [8*COORD_W-1:0] rand_pair();
        int                    kind;
        int                    sz;
        int                    ax, ay, aw, ah, bx, by;
        logic [4*COORD_W-1:0]  box_a;
        logic [4*COORD_W-1:0]  box_b;
        kind = $urandom_range(99, 0);
        case ($urandom_range(3, 0))
            0:       sz = 4;
            1:       sz = 64;
            2:       sz = 1024;
            default: sz = 65535;
        endcase
        if (kind >= 72 && kind < 80)
            sz = 65535;
        ax = rand_coord();
        ay = rand_coord();
        aw = $urandom_range(sz, 0);
        ah = $urandom_range(sz, 0);
        box_a = box_at(ax, ay, aw, ah);
        bx = ax + int'($urandom_range(2 * sz, 0)) - sz;
        by = ay + int'($urandom_range(2 * sz, 0)) - sz;
        box_b = box_at(bx, by, $urandom_range(sz, 0), $urandom_range(sz, 0));
        if (kind < 80) begin
            return {box_b, box_a};
        end else if (kind < 88) begin
            return {box_a, box_a};
        end else if (kind < 96) begin
            return {$urandom, $urandom, $urandom, $urandom};
        end else begin
            // swap the x corners of box A
            return {box_b, box_a[4*COORD_W-1:3*COORD_W], box_a[COORD_W-1:0],
                    box_a[2*COORD_W-1:COORD_W], box_a[3*COORD_W-1:2*COORD_W]};
        end
    endfunction

    function automatic logic [8*COORD_W-1:0] pair_of(int ax1, int ay1, int ax2, int ay2,
                                                     int bx1, int by1, int bx2, int by2);
        return {COORD_W'(by2), COORD_W'(bx2), COORD_W'(by1), COORD_W'(bx1),
                COORD_W'(ay2), COORD_W'(ax2), COORD_W'(ay1), COORD_W'(ax1)};
    endfunction

    // Issue one request; called and returns at a falling edge
    task automatic send_pair(logic [8*COORD_W-1:0] pair);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pair;
        do begin
            @(posedge aclk);
        end while (!s_axis_tready);
        @(negedge aclk);
    endtask

    // Hold input until every expected result is back, then let the pipe settle
    task automatic drain_pipe();
        s_axis_tvalid <= 1'b0;
        @(negedge aclk);
        while (pending != 0)
            @(negedge aclk);
        repeat (LATENCY + 4) @(negedge aclk);
    endtask

    task automatic write_bias(logic [biou_pkg::BIAS_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic run_random(int n, int hold_at);
        int i;
        for (i = 0; i < n; i++) begin
            if (i == hold_at)
                drain_pipe();
            send_pair(rand_pair());
        end
    endtask

    initial begin
        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed pairs under the reset bias
        send_pair(pair_of(0, 0, 10, 10, 0, 0, 10, 10));
        send_pair(pair_of(0, 0, 10, 10, 20, 20, 30, 30));
        send_pair(pair_of(0, 0, 10, 10, 10, 0, 20, 10));
        send_pair(pair_of(0, 0, 100, 100, 25, 25, 75, 75));
        send_pair(pair_of(0, 0, 10, 10, 5, 5, 15, 15));
        send_pair(pair_of(-32768, -32768, 32767, 32767, -32768, -32768, 32767, 32767));
        send_pair(pair_of(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768));
        send_pair(pair_of(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
        send_pair(pair_of(-32768, -32768, 32767, 32767, 32766, 32766, 32767, 32767));
        send_pair(pair_of(0, 10, 10, 0, 0, 10, 10, 0));
        send_pair(pair_of(10, 10, 0, 0, 0, 0, 10, 10));
        send_pair(pair_of(32767, -32768, -32768, 32767, 0, 0, 1, 1));
        send_pair(pair_of(-1, -1, 1, 1, 0, 0, 0, 0));
        drain_pipe();

        // Zero bias: identical boxes saturate, empty boxes give no union
        write_bias('0);
        send_pair(pair_of(0, 0, 10, 10, 0, 0, 10, 10));
        send_pair(pair_of(-32768, -32768, 32767, 32767, -32768, -32768, 32767, 32767));
        send_pair(pair_of(0, 0, 0, 0, 0, 0, 0, 0));
        send_pair(pair_of(5, 5, 5, 9, 7, 7, 3, 7));
        send_pair(pair_of(0, 10, 10, 0, 0, 0, 10, 10));
        send_pair(pair_of(0, 0, 10, 10, 5, 5, 15, 15));
        drain_pipe();

        // Largest bias on small and large boxes
        write_bias('1);
        send_pair(pair_of(0, 0, 10, 10, 0, 0, 10, 10));
        send_pair(pair_of(0, 0, 300, 300, 0, 0, 300, 300));
        send_pair(pair_of(-32768, -32768, 32767, 32767, -32768, -32768, 32767, 32767));
        send_pair(pair_of(0, 0, 10, 10, 30, 30, 40, 40));
        drain_pipe();

        // Random phases: slow receiver, then slow sender, then full rate
        write_bias('0);
        send_idle_pct = 20;
        recv_idle_pct = 79;
        run_random(PHASE_ITEMS, 60);
        drain_pipe();

        write_bias('1);
        send_idle_pct = 79;
        recv_idle_pct = 20;
        run_random(PHASE_ITEMS, -1);
        drain_pipe();

        write_bias(biou_pkg::BIAS_W'($urandom_range(65535, 0)));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(PHASE_ITEMS, -1);
        drain_pipe();

        if (mismatches == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/biou_pkg.sv
src/biou_geom.sv
src/biou_div_cell.sv
src/box_iou_unit.sv
test/box_iou_check.sv
test/box_iou_unit_test.sv
